FILE: hdl/cfp_pkg.sv
// Shared constants and types of the circular FIFO with value purge.
package cfp_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W = 32;
	localparam int OP_W = 2;
	localparam int COUNT_OUT_W = 5;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP = 2'd1;
	localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

	localparam logic signed [WORD_W-1:0] UNDERFLOW_WORD = -32'sd1;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_data;
		logic pop_underflow;
		logic push_dropped;
		logic is_empty;
		logic is_full;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

endpackage

FILE: hdl/cfp_if.sv
// Request and response channel interfaces of the circular FIFO with value purge.
interface cfp_req_if
	import cfp_pkg::*;
	();
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, operation, value, input ready);
	modport sink (input valid, operation, value, output ready);
endinterface

interface cfp_rsp_if
	import cfp_pkg::*;
	();
	logic valid;
	logic ready;
	logic signed [WORD_W-1:0] read_data;
	logic pop_underflow;
	logic push_dropped;
	logic is_empty;
	logic is_full;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, read_data, pop_underflow, push_dropped, is_empty, is_full,
		entry_count, input ready);
	modport sink (input valid, read_data, pop_underflow, push_dropped, is_empty, is_full,
		entry_count, output ready);
endinterface

FILE: hdl/cfp_ram.sv
// Entry store: one write port and one read port with registered read data.
module cfp_ram
	import cfp_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic signed [WORD_W-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic signed [WORD_W-1:0] rdata
);

	logic signed [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/circular_fifo_with_value_purge_core.sv
// Top level of the circular FIFO with value purge: sequencer around the entry store.
//
// A push, a pop of an empty queue and a purge of an empty queue load their result straight
// from the idle state. A pop of a held entry first passes through the pop state, which loads
// the result from the registered read of the entry store. A purge walks the held entries
// through the store's single read port, one entry per cycle, and compacts the survivors in
// place, starting at the slot of the oldest entry. One operation is in flight at a time. A
// new request is taken only when the output register is empty or its result is transferred
// in the same cycle, so a waiting result stalls the input.
module circular_fifo_with_value_purge_core
	import cfp_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	cfp_req_if.sink req,
	cfp_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_PURGE
	} state_t;

	state_t state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] rd_cnt_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] kept_q;
	logic signed [WORD_W-1:0] pval_q;
	logic chk_s1;
	logic out_valid_q;
	rsp_t out_q;

	logic acc;
	logic out_free;
	logic is_empty_now;
	logic is_full_now;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_slot;
	logic issue;
	logic keep;
	logic [CW-1:0] kept_next;
	logic res_load;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic signed [WORD_W-1:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic signed [WORD_W-1:0] mem_rdata;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	function automatic rsp_t make_rsp(input logic signed [WORD_W-1:0] data, input logic uf,
		input logic dr, input logic [CW-1:0] c);
		rsp_t r;
		r.read_data = data;
		r.pop_underflow = uf;
		r.push_dropped = dr;
		r.is_empty = (c == '0);
		r.is_full = (c == CW'(DEPTH));
		r.entry_count = COUNT_OUT_W'(c);
		return r;
	endfunction

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc = req.valid && req.ready;

	assign is_empty_now = (cnt_q == '0);
	assign is_full_now = (cnt_q == CW'(DEPTH));

	assign tail_sum = SW'(head_q) + SW'(cnt_q);
	assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

	assign issue = (rd_cnt_q != cnt_q);
	assign keep = chk_s1 && (mem_rdata != pval_q);
	assign kept_next = keep ? kept_q + CW'(1) : kept_q;

	assign res_load = ((state_q == ST_IDLE) && acc && !(!is_empty_now &&
		((req.operation == OP_POP) || (req.operation == OP_PURGE))))
		|| (state_q == ST_POP) || ((state_q == ST_PURGE) && !issue);

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (state_q == ST_IDLE) begin
			mem_waddr = tail_slot;
			mem_wdata = req.value;
			mem_raddr = head_q;
			if (acc) begin
				mem_we = (req.operation == OP_PUSH) && !is_full_now;
				mem_re = ((req.operation == OP_POP) || (req.operation == OP_PURGE))
					&& !is_empty_now;
			end
		end else begin
			mem_waddr = wr_ptr_q;
			mem_wdata = mem_rdata;
			mem_raddr = rd_ptr_q;
			if (state_q == ST_PURGE) begin
				mem_we = keep;
				mem_re = issue;
			end
		end
	end

	cfp_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			cnt_q <= '0;
			rd_ptr_q <= '0;
			rd_cnt_q <= '0;
			wr_ptr_q <= '0;
			kept_q <= '0;
			chk_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.operation)
							OP_PUSH: begin
								if (is_full_now) begin
									out_q <= make_rsp('0, 1'b0, 1'b1, cnt_q);
								end else begin
									cnt_q <= cnt_q + CW'(1);
									out_q <= make_rsp('0, 1'b0, 1'b0, cnt_q + CW'(1));
								end
							end
							OP_POP: begin
								if (is_empty_now) begin
									out_q <= make_rsp(UNDERFLOW_WORD, 1'b1, 1'b0, cnt_q);
								end else begin
									cnt_q <= cnt_q - CW'(1);
									head_q <= (cnt_q == CW'(1)) ? '0 : slot_inc(head_q);
									state_q <= ST_POP;
								end
							end
							OP_PURGE: begin
								if (is_empty_now) begin
									out_q <= make_rsp('0, 1'b0, 1'b0, cnt_q);
								end else begin
									pval_q <= req.value;
									rd_ptr_q <= slot_inc(head_q);
									rd_cnt_q <= CW'(1);
									wr_ptr_q <= head_q;
									kept_q <= '0;
									chk_s1 <= 1'b1;
									state_q <= ST_PURGE;
								end
							end
							default: begin
								out_q <= make_rsp('0, 1'b0, 1'b0, cnt_q);
							end
						endcase
					end
				end
				ST_POP: begin
					out_q <= make_rsp(mem_rdata, 1'b0, 1'b0, cnt_q);
					state_q <= ST_IDLE;
				end
				ST_PURGE: begin
					chk_s1 <= issue;
					if (issue) begin
						rd_ptr_q <= slot_inc(rd_ptr_q);
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					kept_q <= kept_next;
					if (keep) begin
						wr_ptr_q <= slot_inc(wr_ptr_q);
					end
					if (!issue) begin
						cnt_q <= kept_next;
						if (kept_next == '0) begin
							head_q <= '0;
						end
						out_q <= make_rsp('0, 1'b0, 1'b0, kept_next);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_q.read_data;
	assign rsp.pop_underflow = out_q.pop_underflow;
	assign rsp.push_dropped = out_q.push_dropped;
	assign rsp.is_empty = out_q.is_empty;
	assign rsp.is_full = out_q.is_full;
	assign rsp.entry_count = out_q.entry_count;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("Held count exceeds the queue depth.");

	a_purge_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE) |-> (rd_cnt_q <= cnt_q) && (kept_q < rd_cnt_q || rd_cnt_q == '0))
		else $error("Purge walk read or kept more entries than are held.");

	a_pop_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !out_valid_q)
		else $error("A result is pending while a pop read is in flight.");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("A pop did not deliver its result one cycle after the read.");

	a_purge_write_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("Purge compaction write hit the entry being read.");

endmodule
